// ===== rtl/core/bfd_pkg.sv =====
// Shared types and constants for the Bezier forward-differencing block.
package bfd_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIFF_W     = 48;
  localparam int unsigned EXT_BITS   = 15;
  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned NUM_W      = 64;
  localparam int unsigned DEN_W      = 18;
  localparam int unsigned LEN_W      = 32;

  localparam logic [CNT_W-1:0] POINT_COUNT_RST = CNT_W'(16);
  localparam logic [CNT_W-1:0] POINT_COUNT_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] POINT_COUNT_MAX = CNT_W'(MAX_POINTS);
  localparam logic [1:0]       IDX_P3          = 2'd3;

  // One curve job: P0..P3, each x/y/z, plus the clamped point count
  typedef struct packed {
    logic [3:0][2:0][COORD_W-1:0] pts;
    logic [CNT_W-1:0]             count;
  } run_t;

endpackage

// ===== rtl/core/bfd_front.sv =====
// Front end: control point store, point count register and job issue.
module bfd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     ctrl_index_i,
  input  logic [bfd_pkg::COORD_W-1:0]    ctrl_x_i,
  input  logic [bfd_pkg::COORD_W-1:0]    ctrl_y_i,
  input  logic [bfd_pkg::COORD_W-1:0]    ctrl_z_i,
  input  logic                           point_count_we_i,
  input  logic [bfd_pkg::CNT_W-1:0]      point_count_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output bfd_pkg::run_t                  q_entry_o
);

  logic [bfd_pkg::CNT_W-1:0]   count_q;
  logic [bfd_pkg::CNT_W-1:0]   count_clamped;
  logic [bfd_pkg::COORD_W-1:0] store_q [3][3];
  logic                        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && (ctrl_index_i == bfd_pkg::IDX_P3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= bfd_pkg::POINT_COUNT_RST;
    end else if (point_count_we_i) begin
      count_q <= point_count_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && ctrl_index_i != bfd_pkg::IDX_P3) begin
      store_q[ctrl_index_i][0] <= ctrl_x_i;
      store_q[ctrl_index_i][1] <= ctrl_y_i;
      store_q[ctrl_index_i][2] <= ctrl_z_i;
    end
  end

  always_comb begin
    if (count_q < bfd_pkg::POINT_COUNT_MIN) begin
      count_clamped = bfd_pkg::POINT_COUNT_MIN;
    end else if (count_q > bfd_pkg::POINT_COUNT_MAX) begin
      count_clamped = bfd_pkg::POINT_COUNT_MAX;
    end else begin
      count_clamped = count_q;
    end
  end

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      for (int a = 0; a < 3; a++) begin
        q_entry_o.pts[p][a] = store_q[p][a];
      end
    end
    q_entry_o.pts[3][0] = ctrl_x_i;
    q_entry_o.pts[3][1] = ctrl_y_i;
    q_entry_o.pts[3][2] = ctrl_z_i;
    q_entry_o.count     = count_clamped;
  end

endmodule

// ===== rtl/core/bfd_queue.sv =====
// Two-entry job queue between front end and curve engine.
module bfd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bfd_pkg::run_t entry_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bfd_pkg::run_t entry_o
);

  bfd_pkg::run_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    fill_q;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/bfd_divider.sv =====
// Iterative signed divide, rounded to nearest (ties away from zero), one bit per cycle.
module bfd_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [bfd_pkg::NUM_W-1:0]  num_i,
  input  logic [bfd_pkg::DEN_W-1:0]         den_i,
  output logic                              done_o,
  output logic [bfd_pkg::DIFF_W-1:0]        quo_o
);

  logic [bfd_pkg::NUM_W-1:0] dvd_q, dvd_d;
  logic [bfd_pkg::DEN_W-1:0] rem_q, rem_d;
  logic [bfd_pkg::DEN_W-1:0] den_q;
  logic [bfd_pkg::DEN_W:0]   rem_sh;
  logic [5:0]                cnt_q;
  logic                      busy_q, done_q, neg_q;
  logic [bfd_pkg::NUM_W-1:0] mag;
  logic                      ge;

  assign mag    = num_i[bfd_pkg::NUM_W-1] ? (~num_i + 1'b1) : num_i;
  assign rem_sh = {rem_q, dvd_q[bfd_pkg::NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    dvd_d = {dvd_q[bfd_pkg::NUM_W-2:0], ge};
    rem_d = ge ? bfd_pkg::DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[bfd_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= mag + bfd_pkg::NUM_W'(den_i >> 1);
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[bfd_pkg::NUM_W-1];
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? (~dvd_q[bfd_pkg::DIFF_W-1:0] + 1'b1) : dvd_q[bfd_pkg::DIFF_W-1:0];

endmodule

// ===== rtl/core/bfd_back.sv =====
// Curve engine: coefficient setup, forward differencing, path length, output register.
module bfd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  bfd_pkg::run_t                    q_entry_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bfd_pkg::COORD_W-1:0]      curve_x_o,
  output logic [bfd_pkg::COORD_W-1:0]      curve_y_o,
  output logic [bfd_pkg::COORD_W-1:0]      curve_z_o,
  output logic [bfd_pkg::LEN_W-1:0]        path_length_o,
  output logic                             last_point_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_M2    = 4'd1;
  localparam logic [3:0] ST_M3    = 4'd2;
  localparam logic [3:0] ST_COEF  = 4'd3;
  localparam logic [3:0] ST_MUL1  = 4'd4;
  localparam logic [3:0] ST_MUL2  = 4'd5;
  localparam logic [3:0] ST_DIVS  = 4'd6;
  localparam logic [3:0] ST_DIVW  = 4'd7;
  localparam logic [3:0] ST_STEP  = 4'd8;
  localparam logic [3:0] ST_ROUND = 4'd9;
  localparam logic [3:0] ST_SQ    = 4'd10;
  localparam logic [3:0] ST_SQRT  = 4'd11;
  localparam logic [3:0] ST_ACC   = 4'd12;
  localparam logic [3:0] ST_EMIT  = 4'd13;

  localparam int unsigned CW = bfd_pkg::COORD_W;
  localparam int unsigned DW = bfd_pkg::DIFF_W;
  localparam int unsigned NW = bfd_pkg::NUM_W;

  logic [3:0]                  state_q;
  logic [3:0][2:0][CW-1:0]     pts_q;
  logic [bfd_pkg::CNT_W-1:0]   n_q, k_q;
  logic [5:0]                  m_q;
  logic [11:0]                 mm_q;
  logic [bfd_pkg::DEN_W-1:0]   m3_q;
  logic [1:0]                  ax_q, sel_q, sq_ax_q;

  logic signed [39:0]          b_q, c_q, d_q;
  logic signed [NW-1:0]        bm_q, cm_q, t2_q, num2_q, num3_q;
  logic signed [NW-1:0]        num1, div_num;
  logic signed [NW-1:0]        m_s;

  logic [DW-1:0]               poly_q [3];
  logic [DW-1:0]               d1_q [3];
  logic [DW-1:0]               d2_q [3];
  logic [DW-1:0]               d3_q [3];
  logic [CW-1:0]               pt_q [3];
  logic [CW-1:0]               prev_q [3];

  logic [63:0]                 sum_q, x_q, res_q, bit_q;
  logic                        sat_q;
  logic [bfd_pkg::LEN_W-1:0]   len_q;

  logic                        div_start, div_done;
  logic [DW-1:0]               div_quo;

  logic signed [CW:0]          dd;
  logic [CW:0]                 dmag;
  logic [63:0]                 sq;
  logic [64:0]                 sum_ext;
  logic [63:0]                 trial;
  logic [CW:0]                 seg_dist;
  logic [bfd_pkg::LEN_W+1:0]   len_sum;

  logic                        out_valid_q, out_last_q, out_load;
  logic [CW-1:0]               out_x_q, out_y_q, out_z_q;
  logic [bfd_pkg::LEN_W-1:0]   out_len_q;

  function automatic logic [CW-1:0] to_coord(input logic [DW-1:0] r);
    logic signed [DW:0]    t;
    logic signed [DW-15:0] v;
    t = $signed({r[DW-1], r}) + (DW+1)'(1 << (bfd_pkg::EXT_BITS - 1));
    v = (DW-14)'(t >>> bfd_pkg::EXT_BITS);
    if (v > (DW-14)'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (v < (DW-14)'(signed'({1'b1, {(CW-1){1'b0}}}))) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return v[CW-1:0];
    end
  endfunction

  bfd_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (m3_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign m_s       = NW'($signed({1'b0, m_q}));
  assign num1      = (t2_q + NW'(d_q)) <<< bfd_pkg::EXT_BITS;
  assign div_start = state_q == ST_DIVS;
  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    unique case (sel_q)
      2'd0:    div_num = num1;
      2'd1:    div_num = num2_q;
      default: div_num = num3_q;
    endcase
  end

  assign dd       = $signed({pt_q[sq_ax_q][CW-1], pt_q[sq_ax_q]})
                  - $signed({prev_q[sq_ax_q][CW-1], prev_q[sq_ax_q]});
  assign dmag     = dd[CW] ? (~dd + 1'b1) : dd;
  assign sq       = dmag[CW-1:0] * dmag[CW-1:0];
  assign sum_ext  = {1'b0, sum_q} + {1'b0, sq};
  assign trial    = res_q + bit_q;
  assign seg_dist = sat_q ? {1'b1, {CW{1'b0}}}
                          : (CW+1)'(res_q) + (CW+1)'(x_q > res_q);
  assign len_sum  = (bfd_pkg::LEN_W+2)'(len_q) + (bfd_pkg::LEN_W+2)'(seg_dist);
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
      ax_q        <= '0;
      sel_q       <= '0;
      sq_ax_q     <= '0;
      len_q       <= '0;
      for (int a = 0; a < 3; a++) begin
        poly_q[a] <= '0;
        d1_q[a]   <= '0;
        d2_q[a]   <= '0;
        d3_q[a]   <= '0;
        prev_q[a] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            n_q     <= q_entry_i.count;
            ax_q    <= '0;
            state_q <= ST_M2;
          end
        end
        ST_M2:   state_q <= ST_M3;
        ST_M3:   state_q <= ST_COEF;
        ST_COEF: begin
          poly_q[ax_q] <= {pts_q[0][ax_q][CW-1], pts_q[0][ax_q], {bfd_pkg::EXT_BITS{1'b0}}};
          state_q      <= ST_MUL1;
        end
        ST_MUL1: state_q <= ST_MUL2;
        ST_MUL2: begin
          sel_q   <= '0;
          state_q <= ST_DIVS;
        end
        ST_DIVS: state_q <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            unique case (sel_q)
              2'd0:    d1_q[ax_q] <= div_quo;
              2'd1:    d2_q[ax_q] <= div_quo;
              default: d3_q[ax_q] <= div_quo;
            endcase
            if (sel_q == 2'd2) begin
              if (ax_q == 2'd2) begin
                k_q     <= '0;
                len_q   <= '0;
                state_q <= ST_ROUND;
              end else begin
                ax_q    <= ax_q + 2'd1;
                state_q <= ST_COEF;
              end
            end else begin
              sel_q   <= sel_q + 2'd1;
              state_q <= ST_DIVS;
            end
          end
        end
        ST_STEP: begin
          for (int a = 0; a < 3; a++) begin
            poly_q[a] <= poly_q[a] + d1_q[a];
            d1_q[a]   <= d1_q[a] + d2_q[a];
            d2_q[a]   <= d2_q[a] + d3_q[a];
          end
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          sq_ax_q <= '0;
          state_q <= (k_q == '0) ? ST_EMIT : ST_SQ;
        end
        ST_SQ: begin
          sq_ax_q <= sq_ax_q + 2'd1;
          if (sq_ax_q == 2'd2) begin
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (bit_q[0]) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          len_q   <= len_sum[bfd_pkg::LEN_W+1:bfd_pkg::LEN_W] != 2'b00
                   ? {bfd_pkg::LEN_W{1'b1}} : len_sum[bfd_pkg::LEN_W-1:0];
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            for (int a = 0; a < 3; a++) begin
              prev_q[a] <= pt_q[a];
            end
            k_q     <= k_q + 1'b1;
            state_q <= (k_q == n_q - 1'b1) ? ST_IDLE : ST_STEP;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pts_q <= q_entry_i.pts;
      m_q   <= 6'(q_entry_i.count - 1'b1);
    end
    if (state_q == ST_M2) begin
      mm_q <= m_q * m_q;
    end
    if (state_q == ST_M3) begin
      m3_q <= mm_q * m_q;
    end
    if (state_q == ST_COEF) begin
      b_q <= 40'sd3 * (40'($signed(pts_q[1][ax_q])) - 40'($signed(pts_q[0][ax_q])));
      c_q <= 40'sd3 * (40'($signed(pts_q[2][ax_q])) - (40'($signed(pts_q[1][ax_q])) <<< 1)
                       + 40'($signed(pts_q[0][ax_q])));
      d_q <= 40'($signed(pts_q[3][ax_q])) - 40'sd3 * 40'($signed(pts_q[2][ax_q]))
           + 40'sd3 * 40'($signed(pts_q[1][ax_q])) - 40'($signed(pts_q[0][ax_q]));
    end
    if (state_q == ST_MUL1) begin
      bm_q <= NW'(b_q) * m_s;
      cm_q <= NW'(c_q) * m_s;
    end
    if (state_q == ST_MUL2) begin
      t2_q   <= (bm_q + NW'(c_q)) * m_s;
      num2_q <= ((cm_q <<< 1) + NW'(d_q) * 64'sd6) <<< bfd_pkg::EXT_BITS;
      num3_q <= (NW'(d_q) * 64'sd6) <<< bfd_pkg::EXT_BITS;
    end
    if (state_q == ST_ROUND) begin
      for (int a = 0; a < 3; a++) begin
        pt_q[a] <= to_coord(poly_q[a]);
      end
      sum_q <= '0;
      sat_q <= 1'b0;
    end
    if (state_q == ST_SQ) begin
      sum_q <= sum_ext[63:0];
      if (dmag[CW] || sum_ext[64]) begin
        sat_q <= 1'b1;
      end
      if (sq_ax_q == 2'd2) begin
        x_q   <= sum_ext[63:0];
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
    end
    if (state_q == ST_SQRT) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (out_load) begin
      out_x_q    <= pt_q[0];
      out_y_q    <= pt_q[1];
      out_z_q    <= pt_q[2];
      out_len_q  <= len_q;
      out_last_q <= k_q == n_q - 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign curve_x_o     = out_x_q;
  assign curve_y_o     = out_y_q;
  assign curve_z_o     = out_z_q;
  assign path_length_o = out_len_q;
  assign last_point_o  = out_last_q;

  a_emit_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (k_q < n_q))
    else $error("emit beyond point count");

  a_first_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && k_q == '0) |=> (path_length_o == '0))
    else $error("first point carries non-zero length");

  a_sqrt_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> $onehot(bit_q))
    else $error("square root bit lost");

endmodule

// ===== rtl/core/bezier_forward_difference.sv =====
// Top level: cubic Bezier curve generator by third-order forward differencing.
// A P0..P2 transaction is taken while the queue is not full; P3 queues a curve job (two-deep queue).
// Job setup runs nine serial divides by (N-1)^3.
// Then each further curve point is paced by the 32-step serial square root.
// The first point leaves after job setup; output stalls only hold the engine.
// Reset is asynchronous, active low; point count resets to 16, queue and engine empty.
module bezier_forward_difference (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     ctrl_index_i,
  input  logic [bfd_pkg::COORD_W-1:0]    ctrl_x_i,
  input  logic [bfd_pkg::COORD_W-1:0]    ctrl_y_i,
  input  logic [bfd_pkg::COORD_W-1:0]    ctrl_z_i,
  input  logic                           point_count_we_i,
  input  logic [bfd_pkg::CNT_W-1:0]      point_count_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bfd_pkg::COORD_W-1:0]    curve_x_o,
  output logic [bfd_pkg::COORD_W-1:0]    curve_y_o,
  output logic [bfd_pkg::COORD_W-1:0]    curve_z_o,
  output logic [bfd_pkg::LEN_W-1:0]      path_length_o,
  output logic                           last_point_o
);

  logic          q_push, q_full, q_pop, q_valid;
  bfd_pkg::run_t q_wr_entry, q_rd_entry;

  bfd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .ctrl_index_i     (ctrl_index_i),
    .ctrl_x_i         (ctrl_x_i),
    .ctrl_y_i         (ctrl_y_i),
    .ctrl_z_i         (ctrl_z_i),
    .point_count_we_i (point_count_we_i),
    .point_count_i    (point_count_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_entry_o        (q_wr_entry)
  );

  bfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_rd_entry)
  );

  bfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_rd_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .curve_x_o     (curve_x_o),
    .curve_y_o     (curve_y_o),
    .curve_z_o     (curve_z_o),
    .path_length_o (path_length_o),
    .last_point_o  (last_point_o)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for bezier_forward_difference: directed and random curve jobs against a predictor.
module tb;

  typedef struct {
    logic [bfd_pkg::COORD_W-1:0] x, y, z;
    logic [bfd_pkg::LEN_W-1:0]   len;
    logic                        last;
  } curve_pt_t;

  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic [1:0] ctrl_index_i;
  logic [bfd_pkg::COORD_W-1:0] ctrl_x_i, ctrl_y_i, ctrl_z_i;
  logic point_count_we_i;
  logic [bfd_pkg::CNT_W-1:0] point_count_i;
  logic out_valid_o, out_ready_i;
  logic [bfd_pkg::COORD_W-1:0] curve_x_o, curve_y_o, curve_z_o;
  logic [bfd_pkg::LEN_W-1:0] path_length_o;
  logic last_point_o;

  bezier_forward_difference dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .ctrl_index_i, .ctrl_x_i, .ctrl_y_i,
    .ctrl_z_i, .point_count_we_i, .point_count_i, .out_valid_o, .out_ready_i,
    .curve_x_o, .curve_y_o, .curve_z_o, .path_length_o, .last_point_o
  );

  curve_pt_t  pending_pts[$];
  logic [bfd_pkg::COORD_W-1:0] ctrl_pts[4][3];
  logic [bfd_pkg::CNT_W-1:0]   count_reg;
  int unsigned errors;
  int unsigned cycles;
  bit no_gaps;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic [bfd_pkg::DIFF_W-1:0] div_near(input longint num, input longint den);
    longint unsigned mag, q;
    mag = num < 0 ? longint'(0) - num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? bfd_pkg::DIFF_W'(longint'(0) - q) : bfd_pkg::DIFF_W'(q);
  endfunction

  function automatic logic [bfd_pkg::COORD_W-1:0] to_coord(
      input logic [bfd_pkg::DIFF_W-1:0] r);
    longint t;
    t = longint'(signed'(r)) + (longint'(1) <<< (bfd_pkg::EXT_BITS - 1));
    t = t >>> bfd_pkg::EXT_BITS;
    if (t > 64'sh7FFF_FFFF) t = 64'sh7FFF_FFFF;
    if (t < -64'sh8000_0000) t = -64'sh8000_0000;
    return t[bfd_pkg::COORD_W-1:0];
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Euclidean step length; 2^32 or more means saturated
  function automatic longint unsigned step_len(input longint pa[3], input longint pb[3]);
    logic [64:0] sum;
    longint unsigned mg, r;
    longint dd;
    sum = 0;
    for (int a = 0; a < 3; a++) begin
      dd = pa[a] - pb[a];
      mg = dd < 0 ? longint'(0) - dd : dd;
      if (mg >= 64'h1_0000_0000) return 64'h1_0000_0000;
      sum += 65'(mg * mg);
      if (sum[64]) return 64'h1_0000_0000;
    end
    r = int_sqrt(sum[63:0]);
    if (sum[63:0] - r * r > r) r++;
    return r;
  endfunction

  task automatic predict_curve();
    int n;
    longint m, m3, p0, p1, p2, p3, b, c, d;
    logic [bfd_pkg::DIFF_W-1:0] poly[3], d1[3], d2[3], d3[3];
    longint pt[3], prev[3];
    longint unsigned acc;
    curve_pt_t e;
    n = count_reg < bfd_pkg::POINT_COUNT_MIN ? bfd_pkg::POINT_COUNT_MIN :
        count_reg > bfd_pkg::POINT_COUNT_MAX ? bfd_pkg::POINT_COUNT_MAX : count_reg;
    m = n - 1;
    m3 = m * m * m;
    for (int a = 0; a < 3; a++) begin
      p0 = longint'(signed'(ctrl_pts[0][a]));
      p1 = longint'(signed'(ctrl_pts[1][a]));
      p2 = longint'(signed'(ctrl_pts[2][a]));
      p3 = longint'(signed'(ctrl_pts[3][a]));
      b = 3 * (p1 - p0);
      c = 3 * (p2 - 2 * p1 + p0);
      d = p3 - 3 * p2 + 3 * p1 - p0;
      poly[a] = bfd_pkg::DIFF_W'(p0 <<< bfd_pkg::EXT_BITS);
      d1[a] = div_near((b * m * m + c * m + d) <<< bfd_pkg::EXT_BITS, m3);
      d2[a] = div_near((2 * c * m + 6 * d) <<< bfd_pkg::EXT_BITS, m3);
      d3[a] = div_near((6 * d) <<< bfd_pkg::EXT_BITS, m3);
    end
    acc = 0;
    for (int k = 0; k < n; k++) begin
      if (k > 0)
        for (int a = 0; a < 3; a++) begin
          poly[a] += d1[a];
          d1[a] += d2[a];
          d2[a] += d3[a];
        end
      for (int a = 0; a < 3; a++) pt[a] = longint'(signed'(to_coord(poly[a])));
      if (k > 0) begin
        acc += step_len(pt, prev);
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      end
      prev = pt;
      e.x = pt[0][31:0];
      e.y = pt[1][31:0];
      e.z = pt[2][31:0];
      e.len = acc[31:0];
      e.last = (k + 1 == n);
      pending_pts = {pending_pts, e};
    end
  endtask

  task automatic send_ctrl(input logic [1:0] idx, input logic [bfd_pkg::COORD_W-1:0] x,
                           input logic [bfd_pkg::COORD_W-1:0] y,
                           input logic [bfd_pkg::COORD_W-1:0] z);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    ctrl_index_i <= idx;
    ctrl_x_i     <= x;
    ctrl_y_i     <= y;
    ctrl_z_i     <= z;
    do @(posedge clk_i); while (!in_ready_o);
    ctrl_pts[idx][0] = x;
    ctrl_pts[idx][1] = y;
    ctrl_pts[idx][2] = z;
    if (idx == bfd_pkg::IDX_P3) predict_curve();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_count(input logic [bfd_pkg::CNT_W-1:0] v);
    drain();
    point_count_we_i <= 1'b1;
    point_count_i    <= v;
    @(posedge clk_i);
    point_count_we_i <= 1'b0;
    count_reg = v;
  endtask

  function automatic logic [bfd_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return bfd_pkg::COORD_W'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_rand(input logic [1:0] idx);
    send_ctrl(idx, rand_coord(), rand_coord(), rand_coord());
  endtask

  // reset count of 16, full-range corners
  task automatic test_extremes();
    send_ctrl(2'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_ctrl(2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_ctrl(2'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    send_ctrl(2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_ctrl(2'd0, 32'h0, 32'h0, 32'h0);
    send_ctrl(2'd1, 32'h0, 32'h0, 32'h0);
    send_ctrl(2'd2, 32'h0, 32'h0, 32'h0);
    send_ctrl(2'd3, 32'h0, 32'h0, 32'h0);
    send_ctrl(2'd3, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000);
  endtask

  // counts below and above the legal range, and both bounds
  task automatic test_counts();
    logic [bfd_pkg::CNT_W-1:0] vals[6] = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127};
    foreach (vals[i]) begin
      set_count(vals[i]);
      send_rand(2'd2);
      send_rand(2'd3);
    end
  endtask

  // repeated P3 re-runs with the stored points
  task automatic test_repeat_run();
    set_count(7'd5);
    no_gaps = 1;
    send_rand(2'd3);
    send_rand(2'd3);
    send_rand(2'd1);
    send_rand(2'd3);
    no_gaps = 0;
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 20; ph++) begin
      if ($urandom_range(0, 5) == 0) set_count(bfd_pkg::CNT_W'($urandom_range(60, 127)));
      else set_count(bfd_pkg::CNT_W'($urandom_range(0, 12)));
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int s = 0; s < 5; s++) begin
        if ($urandom_range(0, 4) == 0) begin
          for (int j = 0; j < 4; j++) send_rand(2'($urandom));
        end else begin
          for (int j = 0; j < 4; j++) send_rand(2'(j));
        end
      end
      if (ph == 10) drain();
    end
    no_gaps = 0;
  endtask

  initial begin
    curve_pt_t e;
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_pts.size() == 0) begin
        report("unexpected transaction", curve_x_o, 64'd0);
      end else begin
        e = pending_pts.pop_front();
        if (curve_x_o !== e.x) report("curve_x", curve_x_o, e.x);
        if (curve_y_o !== e.y) report("curve_y", curve_y_o, e.y);
        if (curve_z_o !== e.z) report("curve_z", curve_z_o, e.z);
        if (path_length_o !== e.len) report("path_length", path_length_o, e.len);
        if (last_point_o !== e.last) report("last_point", last_point_o, e.last);
      end
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    no_gaps = 0;
    count_reg = bfd_pkg::POINT_COUNT_RST;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    ctrl_index_i = '0;
    ctrl_x_i = '0;
    ctrl_y_i = '0;
    ctrl_z_i = '0;
    point_count_we_i = 1'b0;
    point_count_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_counts();
    test_repeat_run();
    test_random();
    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_pts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/bfd_pkg.sv
rtl/core/bfd_front.sv
rtl/core/bfd_queue.sv
rtl/core/bfd_divider.sv
rtl/core/bfd_back.sv
rtl/core/bezier_forward_difference.sv
test/tb.sv
